// ===== src/gzip_header_parser_top_macros.svh =====
// Assertion macros used by the gzip header parser checker
`ifndef GZIP_HEADER_PARSER_TOP_MACROS_SVH
`define GZIP_HEADER_PARSER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define GHP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define GHP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is checked through reset as well
`define GHP_ASSERT_NXT_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/ghp_pkg.sv =====
// Shared types and status codes of the gzip header parser
`timescale 1ns / 1ps

package ghp_pkg;

    // Result status codes
    localparam logic [2:0] ST_HEADER  = 3'd0;
    localparam logic [2:0] ST_NAME    = 3'd1;
    localparam logic [2:0] ST_DONE    = 3'd2;
    localparam logic [2:0] ST_PAYLOAD = 3'd3;
    localparam logic [2:0] ST_ERROR   = 3'd4;

    // One input transaction
    typedef struct packed {
        logic [7:0] data_byte;
        logic       restart;
    } t_item;

    // One result transaction
    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  byte_out;
        logic [4:0]  flag_bits;
        logic [31:0] mod_time;
        logic [7:0]  extra_flags;
        logic [7:0]  os_code;
    } t_result;

endpackage

// ===== src/ghp_in_if.sv =====
// Input byte channel of the gzip header parser
`timescale 1ns / 1ps

interface ghp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       restart;

    modport source (output valid, output data_byte, output restart, input ready);
    modport sink   (input valid, input data_byte, input restart, output ready);
endinterface

// ===== src/ghp_out_if.sv =====
// Result channel of the gzip header parser
`timescale 1ns / 1ps

interface ghp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [7:0]  byte_out;
    logic [4:0]  flag_bits;
    logic [31:0] mod_time;
    logic [7:0]  extra_flags;
    logic [7:0]  os_code;

    modport source (output valid, output status, output byte_out, output flag_bits,
                    output mod_time, output extra_flags, output os_code, input ready);
    modport sink   (input valid, input status, input byte_out, input flag_bits,
                    input mod_time, input extra_flags, input os_code, output ready);
endinterface

// ===== src/gzip_header_parser_top.sv =====
// gzip member header parser, top level with the result register
//
// Usage: raw gzip bytes enter on i_in_ch (data_byte plus restart, set on the
// first magic byte of a new stream). Each input transaction yields exactly one
// result transaction on o_out_ch: a status code (header, name byte, header
// complete, payload, error), the echoed byte, and the header fields FLG, MTIME,
// XFL and OS as known after that byte.
// Path: a byte accepted into the input register is parsed by the state logic
// and captured in the result register, which presents it on o_out_ch.
// Throughput: one byte per cycle while o_out_ch.ready is high, set by the state
// update of the header state machine; both stages refill in the cycle they drain.
// Reset (i_rst_n low, synchronous) empties both stages and returns the parser
// to the first magic byte with OS at 255 and all other fields zero.
// When the receiver holds o_out_ch.ready low, the result stays put, the held
// input byte waits, and i_in_ch.ready drops once the input register is full.
// An error (bad magic, method or reserved flag) persists until restart.
`timescale 1ns / 1ps

module gzip_header_parser_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ghp_in_if.sink    i_in_ch,
    ghp_out_if.source o_out_ch
);

    logic             in_valid;
    ghp_pkg::t_item   in_item;
    logic             take;
    ghp_pkg::t_result step_res;
    logic             r_out_valid;
    ghp_pkg::t_result r_out;

    // Move the held byte when the result register is free or draining
    assign take = in_valid && (!r_out_valid || o_out_ch.ready);

    ghp_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in_ch (i_in_ch),
        .i_take  (take),
        .o_valid (in_valid),
        .o_item  (in_item)
    );

    ghp_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (take),
        .i_item   (in_item),
        .o_result (step_res)
    );

    // Result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || o_out_ch.ready) begin
            r_out_valid <= in_valid;
        end
    end

    // Result register payload
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= step_res;
        end
    end

    assign o_out_ch.valid       = r_out_valid;
    assign o_out_ch.status      = r_out.status;
    assign o_out_ch.byte_out    = r_out.byte_out;
    assign o_out_ch.flag_bits   = r_out.flag_bits;
    assign o_out_ch.mod_time    = r_out.mod_time;
    assign o_out_ch.extra_flags = r_out.extra_flags;
    assign o_out_ch.os_code     = r_out.os_code;

endmodule

// ===== src/ghp_in_stage.sv =====
// Input register stage: holds one byte transaction until the parser takes it
`timescale 1ns / 1ps

module ghp_in_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    ghp_in_if.sink          i_in_ch,
    input  logic            i_take,
    output logic            o_valid,
    output ghp_pkg::t_item  o_item
);

    logic           r_valid;
    ghp_pkg::t_item r_item;

    // Refill whenever the held transaction leaves or the stage is empty
    assign i_in_ch.ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in_ch.ready) begin
            r_valid <= i_in_ch.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_ch.valid && i_in_ch.ready) begin
            r_item.data_byte <= i_in_ch.data_byte;
            r_item.restart   <= i_in_ch.restart;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== src/ghp_parse.sv =====
// Header state machine: state registers and one-byte next-state logic
`timescale 1ns / 1ps

module ghp_parse (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  ghp_pkg::t_item   i_item,
    output ghp_pkg::t_result o_result
);

    // Header sections
    localparam logic [3:0] P_ID1     = 4'd0;
    localparam logic [3:0] P_ID2     = 4'd1;
    localparam logic [3:0] P_CM      = 4'd2;
    localparam logic [3:0] P_FLG     = 4'd3;
    localparam logic [3:0] P_MTIME   = 4'd4;
    localparam logic [3:0] P_XFL     = 4'd5;
    localparam logic [3:0] P_OS      = 4'd6;
    localparam logic [3:0] P_XLEN    = 4'd7;
    localparam logic [3:0] P_EXTRA   = 4'd8;
    localparam logic [3:0] P_NAME    = 4'd9;
    localparam logic [3:0] P_COMMENT = 4'd10;
    localparam logic [3:0] P_HCRC    = 4'd11;
    localparam logic [3:0] P_PAYLOAD = 4'd12;
    localparam logic [3:0] P_ERROR   = 4'd13;

    localparam logic [7:0] MAGIC_ID1  = 8'd31;
    localparam logic [7:0] MAGIC_ID2  = 8'd139;
    localparam logic [7:0] METHOD_DEF = 8'd8;

    typedef struct packed {
        logic [3:0]  phase;
        logic [1:0]  byte_index;
        logic [15:0] skip_left;
        logic [4:0]  flags_seen;
        logic [31:0] time_word;
        logic [7:0]  xfl_byte;
        logic [7:0]  os_byte;
    } t_state;

    localparam t_state RESET_STATE = '{
        phase:      P_ID1,
        byte_index: 2'd0,
        skip_left:  16'd0,
        flags_seen: 5'd0,
        time_word:  32'd0,
        xfl_byte:   8'd0,
        os_byte:    8'hFF
    };

    // First optional section at or after 'from' that FLG enables
    function automatic logic [3:0] next_section(input logic [3:0] from,
                                                input logic [4:0] flg);
        logic [3:0] sect;
        sect = P_PAYLOAD;
        if (from <= P_XLEN && flg[2]) begin
            sect = P_XLEN;
        end else if (from <= P_NAME && flg[3]) begin
            sect = P_NAME;
        end else if (from <= P_COMMENT && flg[4]) begin
            sect = P_COMMENT;
        end else if (from <= P_HCRC && flg[1]) begin
            sect = P_HCRC;
        end
        return sect;
    endfunction

    // Status reported when a section ends
    function automatic logic [2:0] advance_status(input logic [3:0] sect);
        return (sect == P_PAYLOAD) ? ghp_pkg::ST_DONE : ghp_pkg::ST_HEADER;
    endfunction

    t_state     r_state;
    t_state     n_state;
    t_state     cur;
    logic [2:0] st;
    logic [7:0] b;
    logic [4:0] lane;

    // Next state and status for the byte at the stage head
    always_comb begin
        cur     = i_item.restart ? RESET_STATE : r_state;
        n_state = cur;
        b       = i_item.data_byte;
        st      = ghp_pkg::ST_HEADER;
        lane    = {cur.byte_index, 3'b000};
        unique case (cur.phase)
            P_ID1: begin
                n_state.phase = (b == MAGIC_ID1) ? P_ID2 : P_ERROR;
            end
            P_ID2: begin
                n_state.phase = (b == MAGIC_ID2) ? P_CM : P_ERROR;
            end
            P_CM: begin
                n_state.phase = (b == METHOD_DEF) ? P_FLG : P_ERROR;
            end
            P_FLG: begin
                if (b[7:5] != 3'b000) begin
                    n_state.phase = P_ERROR;
                end else begin
                    n_state.flags_seen = b[4:0];
                    n_state.phase      = P_MTIME;
                    n_state.byte_index = 2'd0;
                end
            end
            P_MTIME: begin
                n_state.time_word[lane +: 8] = cur.time_word[lane +: 8] | b;
                if (cur.byte_index == 2'd3) begin
                    n_state.phase      = P_XFL;
                    n_state.byte_index = 2'd0;
                end else begin
                    n_state.byte_index = cur.byte_index + 2'd1;
                end
            end
            P_XFL: begin
                n_state.xfl_byte = b;
                n_state.phase    = P_OS;
            end
            P_OS: begin
                n_state.os_byte    = b;
                n_state.phase      = next_section(P_XLEN, cur.flags_seen);
                n_state.byte_index = 2'd0;
                st                 = advance_status(n_state.phase);
            end
            P_XLEN: begin
                if (cur.byte_index == 2'd0) begin
                    n_state.skip_left  = {8'd0, b};
                    n_state.byte_index = 2'd1;
                end else begin
                    n_state.skip_left  = {b, cur.skip_left[7:0]};
                    n_state.byte_index = 2'd0;
                    if (n_state.skip_left == 16'd0) begin
                        n_state.phase = next_section(P_NAME, cur.flags_seen);
                        st            = advance_status(n_state.phase);
                    end else begin
                        n_state.phase = P_EXTRA;
                    end
                end
            end
            P_EXTRA: begin
                n_state.skip_left = cur.skip_left - 16'd1;
                if (n_state.skip_left == 16'd0) begin
                    n_state.phase      = next_section(P_NAME, cur.flags_seen);
                    n_state.byte_index = 2'd0;
                    st                 = advance_status(n_state.phase);
                end
            end
            P_NAME: begin
                if (b != 8'd0) begin
                    st = ghp_pkg::ST_NAME;
                end else begin
                    n_state.phase      = next_section(P_COMMENT, cur.flags_seen);
                    n_state.byte_index = 2'd0;
                    st                 = advance_status(n_state.phase);
                end
            end
            P_COMMENT: begin
                if (b == 8'd0) begin
                    n_state.phase      = next_section(P_HCRC, cur.flags_seen);
                    n_state.byte_index = 2'd0;
                    st                 = advance_status(n_state.phase);
                end
            end
            P_HCRC: begin
                if (cur.byte_index == 2'd0) begin
                    n_state.byte_index = 2'd1;
                end else begin
                    n_state.phase      = P_PAYLOAD;
                    n_state.byte_index = 2'd0;
                    st                 = ghp_pkg::ST_DONE;
                end
            end
            P_PAYLOAD: begin
                st = ghp_pkg::ST_PAYLOAD;
            end
            default: begin
                // error phase and unused codes stay in error
                n_state.phase = P_ERROR;
            end
        endcase
        if (n_state.phase == P_ERROR) begin
            st = ghp_pkg::ST_ERROR;
        end
    end

    // Parser state advances only when a transaction moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= RESET_STATE;
        end else if (i_fire) begin
            r_state <= n_state;
        end
    end

    // Result fields reflect the state after this byte
    assign o_result.status      = st;
    assign o_result.byte_out    = b;
    assign o_result.flag_bits   = n_state.flags_seen;
    assign o_result.mod_time    = n_state.time_word;
    assign o_result.extra_flags = n_state.xfl_byte;
    assign o_result.os_code     = n_state.os_byte;

endmodule

// ===== src/ghp_checker.sv =====
// Port-level checker for the gzip header parser, bound to the top level
`timescale 1ns / 1ps
`include "gzip_header_parser_top_macros.svh"

module ghp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  i_status,
    input logic [7:0]  i_byte_out,
    input logic [4:0]  i_flag_bits,
    input logic [31:0] i_mod_time,
    input logic [7:0]  i_extra_flags,
    input logic [7:0]  i_os_code
);

    logic [63:0] out_word;
    logic        stalled;
    logic        status_known;
    logic        is_name;
    logic        name_ok;

    // Flattened result payload and helper terms
    assign out_word = {i_status, i_byte_out, i_flag_bits, i_mod_time,
                       i_extra_flags, i_os_code};
    assign stalled  = i_out_valid && !i_out_ready;
    assign status_known = (i_status == ghp_pkg::ST_HEADER) ||
                          (i_status == ghp_pkg::ST_NAME) ||
                          (i_status == ghp_pkg::ST_DONE) ||
                          (i_status == ghp_pkg::ST_PAYLOAD) ||
                          (i_status == ghp_pkg::ST_ERROR);
    assign is_name  = i_out_valid && (i_status == ghp_pkg::ST_NAME);
    assign name_ok  = (i_byte_out != 8'd0) && i_flag_bits[3];

    // Nothing is offered right after a reset edge
    `GHP_ASSERT_NXT_RST(a_reset_empty, !i_rst_n, !i_out_valid, "result valid after reset")

    // A stalled result transaction holds its contents
    `GHP_ASSERT_NXT(a_stall_hold, stalled, i_out_valid && $stable(out_word), "stalled result changed")

    // Status codes stay within the defined set
    `GHP_ASSERT_IMP(a_status_range, i_out_valid, status_known, "bad status code")

    // A name byte is never the terminator and only occurs with FNAME set
    `GHP_ASSERT_IMP(a_name_byte, is_name, name_ok, "name byte without FNAME or zero")

endmodule

bind gzip_header_parser_top ghp_checker u_ghp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out_ch.valid),
    .i_out_ready   (o_out_ch.ready),
    .i_status      (o_out_ch.status),
    .i_byte_out    (o_out_ch.byte_out),
    .i_flag_bits   (o_out_ch.flag_bits),
    .i_mod_time    (o_out_ch.mod_time),
    .i_extra_flags (o_out_ch.extra_flags),
    .i_os_code     (o_out_ch.os_code)
);
